// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ftts_pkg.sv =====
`timescale 1ns / 1ps

package ftts_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MAX_TICKS_DEF     = 64;

	localparam int ACC_W    = 33;
	localparam int PERIOD_W = 32;
	localparam int LIMIT_W  = 7;
	localparam int COUNT_W  = 32;
	localparam int ALPHA_W  = 16;
	localparam int HASH_W   = 64;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [HASH_W-1:0]   HASH_SEED  = 64'd14695981039346656037;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd16667;
	localparam logic [LIMIT_W-1:0]  CATCH_RST  = 7'd8;

	// Register index, taken from bit 2 of the byte address.
	localparam logic REG_TICK_PERIOD  = 1'b0;
	localparam logic REG_MAX_CATCH_UP = 1'b1;

	typedef enum logic [1:0] {
		OP_ADVANCE = 2'd0,
		OP_PAUSE   = 2'd1,
		OP_RESUME  = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef struct packed {
		logic accept;
		logic start_adv;
		logic set_pause;
		logic clr_pause;
		logic restart;
		logic tick;
		logic emit_tick;
		logic catch_up;
		logic div_start;
		logic div_step;
		logic emit_final;
	} ftts_cmd_t;

	typedef struct packed {
		logic ge_one;
		logic ge_two;
		logic done_lt;
		logic done_next_lt;
		logic slot_free;
		logic paused;
		logic div_last;
	} ftts_sts_t;

	// The hash prime is 2^40 + 0x1B3, so the product reduces to shifts and adds.
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ===== sv/fixed_timestep_tick_scheduler_top.sv =====
`timescale 1ns / 1ps
// Flow: pause, resume, restart and paused advances go from the input transfer straight to the
// final state, where the result is loaded; an unpaused advance runs its ticks, then the alpha
// division, then the final state. Only one item is in work at a time; the next input transfer
// is taken only after the final result is loaded, and output stalls can hold up any result.
// Reset is asynchronous, active low: tick state and registers return to their defaults at once.

`include "assert_macros.svh"

module fixed_timestep_tick_scheduler_top import ftts_pkg::*; #(
	parameter int FRACTION_BITS      = FRACTION_BITS_DEF,
	parameter int MAX_TICKS_PER_ITEM = MAX_TICKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [PERIOD_W-1:0] elapsed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                step_valid,
	output logic [HASH_W-1:0]   tick_number,
	output logic [HASH_W-1:0]   run_hash,
	output logic [ALPHA_W-1:0]  alpha,
	output logic                catching_up,
	output logic [COUNT_W-1:0]  catch_up_total,
	output logic                is_paused,
	output logic                last
);

	logic [PERIOD_W-1:0] tick_period;
	logic [LIMIT_W-1:0]  max_catch_up;
	ftts_cmd_t           cmd;
	ftts_sts_t           sts;

	ftts_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tick_period  (tick_period),
		.max_catch_up (max_catch_up)
	);

	ftts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op_t'(op)),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftts_dp #(
		.FRACTION_BITS      (FRACTION_BITS),
		.MAX_TICKS_PER_ITEM (MAX_TICKS_PER_ITEM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_period    (tick_period),
		.max_catch_up   (max_catch_up),
		.elapsed        (elapsed),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.step_valid     (step_valid),
		.tick_number    (tick_number),
		.run_hash       (run_hash),
		.alpha          (alpha),
		.catching_up    (catching_up),
		.catch_up_total (catch_up_total),
		.is_paused      (is_paused),
		.last           (last)
	);

	// After an input transfer the block is busy with that item.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// Results ahead of the final one are always executed ticks with no alpha or flag.
	`ASSERT_IMPLIES(a_early_result, clk, arst_n, out_valid && !last, step_valid && alpha == '0 && !catching_up)
	// When idle, only a final result can still be waiting.
	`ASSERT_IMPLIES(a_idle_holds_final, clk, arst_n, out_valid && !in_stall, last)
	// A tick runs only under the limit and with a full period in the accumulator.
	`ASSERT_IMPLIES(a_tick_legal, clk, arst_n, cmd.tick, sts.ge_one && sts.done_lt && !cmd.catch_up)

endmodule

// ===== sv/ftts_regs.sv =====
`timescale 1ns / 1ps

module ftts_regs import ftts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	output logic [PERIOD_W-1:0] tick_period,
	output logic [LIMIT_W-1:0]  max_catch_up
);

	logic [PERIOD_W-1:0] period_q;
	logic [LIMIT_W-1:0]  catch_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			catch_q  <= CATCH_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TICK_PERIOD:  period_q <= pwdata[PERIOD_W-1:0];
				REG_MAX_CATCH_UP: catch_q  <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TICK_PERIOD:  prdata = period_q;
			REG_MAX_CATCH_UP: prdata = APB_DW'(catch_q);
			default:          prdata = '0;
		endcase
	end

	assign tick_period  = period_q;
	assign max_catch_up = catch_q;

endmodule

// ===== sv/ftts_ctrl.sv =====
`timescale 1ns / 1ps

module ftts_ctrl import ftts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  op_t       op,
	output logic      in_stall,
	input  ftts_sts_t sts,
	output ftts_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINAL
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FINAL;
					case (op)
						OP_ADVANCE: begin
							if (!sts.paused) begin
								cmd.start_adv = 1'b1;
								state_d       = ST_CHECK;
							end
						end
						OP_PAUSE:   cmd.set_pause = 1'b1;
						OP_RESUME:  cmd.clr_pause = 1'b1;
						OP_RESTART: cmd.restart   = 1'b1;
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (!sts.ge_one) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (!sts.done_lt) begin
					cmd.catch_up  = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (sts.ge_two && sts.done_next_lt) begin
					// Another tick follows, so this one goes out now as a non-final result.
					if (sts.slot_free) begin
						cmd.tick      = 1'b1;
						cmd.emit_tick = 1'b1;
					end
				end else begin
					// Final tick: its result waits for alpha.
					cmd.tick = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (sts.slot_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ftts_dp.sv =====
`timescale 1ns / 1ps

module ftts_dp import ftts_pkg::*; #(
	parameter int FRACTION_BITS      = FRACTION_BITS_DEF,
	parameter int MAX_TICKS_PER_ITEM = MAX_TICKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PERIOD_W-1:0] tick_period,
	input  logic [LIMIT_W-1:0]  max_catch_up,
	input  logic [PERIOD_W-1:0] elapsed,
	input  ftts_cmd_t           cmd,
	output ftts_sts_t           sts,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                step_valid,
	output logic [HASH_W-1:0]   tick_number,
	output logic [HASH_W-1:0]   run_hash,
	output logic [ALPHA_W-1:0]  alpha,
	output logic                catching_up,
	output logic [COUNT_W-1:0]  catch_up_total,
	output logic                is_paused,
	output logic                last
);

	localparam int DW = $clog2(MAX_TICKS_PER_ITEM + 1);
	localparam int CW = $clog2(FRACTION_BITS);

	logic [ACC_W-1:0]         accum_q;
	logic [HASH_W-1:0]        tick_q;
	logic [HASH_W-1:0]        hash_q;
	logic [ALPHA_W-1:0]       alpha_q;
	logic                     flag_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     pause_q;
	logic [DW-1:0]            done_q;
	logic [PERIOD_W-1:0]      rem_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [CW-1:0]            dcnt_q;
	logic                     out_valid_q;

	logic [PERIOD_W-1:0]      period_eff;
	logic [LIMIT_W-1:0]       limit;
	logic [LIMIT_W-1:0]       done_ext;
	logic [HASH_W-1:0]        tick_next;
	logic [HASH_W-1:0]        hash_next;
	logic [PERIOD_W:0]        rem_dbl;
	logic                     rem_ge;
	logic [PERIOD_W-1:0]      rem_next;
	logic [FRACTION_BITS-1:0] quo_next;
	logic [ALPHA_W-1:0]       alpha_sat;
	logic                     slot_free;

	assign period_eff = (tick_period == '0) ? PERIOD_W'(1) : tick_period;
	assign limit      = (max_catch_up < LIMIT_W'(MAX_TICKS_PER_ITEM)) ?
	                    max_catch_up : LIMIT_W'(MAX_TICKS_PER_ITEM);
	assign done_ext   = LIMIT_W'(done_q);

	assign tick_next = tick_q + HASH_W'(1);
	assign hash_next = fnv_mul(hash_q ^ tick_next);

	// One restoring division step per cycle; the remainder always stays below the period.
	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_ge   = rem_dbl >= {1'b0, period_eff};
	assign rem_next = rem_ge ? PERIOD_W'(rem_dbl - {1'b0, period_eff}) : rem_dbl[PERIOD_W-1:0];
	assign quo_next = {quo_q[FRACTION_BITS-2:0], rem_ge};

	always_comb begin
		if (FRACTION_BITS > ALPHA_W && (quo_next >> ALPHA_W) != '0) begin
			alpha_sat = '1;
		end else begin
			alpha_sat = ALPHA_W'(quo_next);
		end
	end

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.ge_one       = accum_q >= {1'b0, period_eff};
		sts.ge_two       = {1'b0, accum_q} >= {1'b0, period_eff, 1'b0};
		sts.done_lt      = done_ext < limit;
		sts.done_next_lt = LIMIT_W'(done_ext + LIMIT_W'(1)) < limit;
		sts.slot_free    = slot_free;
		sts.paused       = pause_q;
		sts.div_last     = (dcnt_q == CW'(FRACTION_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			tick_q  <= '0;
			hash_q  <= HASH_SEED;
			alpha_q <= '0;
			flag_q  <= 1'b0;
			count_q <= '0;
			pause_q <= 1'b0;
			done_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cmd.accept) begin
				done_q <= '0;
			end
			if (cmd.start_adv) begin
				accum_q <= accum_q + ACC_W'(elapsed);
				flag_q  <= 1'b0;
			end
			if (cmd.set_pause) begin
				pause_q <= 1'b1;
			end
			if (cmd.clr_pause) begin
				pause_q <= 1'b0;
			end
			if (cmd.restart) begin
				accum_q <= '0;
				tick_q  <= '0;
				hash_q  <= HASH_SEED;
				alpha_q <= '0;
				flag_q  <= 1'b0;
				count_q <= '0;
				pause_q <= 1'b0;
			end
			if (cmd.tick) begin
				tick_q  <= tick_next;
				hash_q  <= hash_next;
				accum_q <= accum_q - ACC_W'(period_eff);
				done_q  <= done_q + DW'(1);
			end
			if (cmd.catch_up) begin
				flag_q  <= 1'b1;
				count_q <= count_q + COUNT_W'(1);
				accum_q <= '0;
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + CW'(1);
				if (sts.div_last) begin
					alpha_q <= alpha_sat;
				end
			end
		end
	end

	// Divider working registers: loaded before use, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= cmd.catch_up ? '0 : accum_q[PERIOD_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_tick || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_tick) begin
			step_valid     <= 1'b1;
			tick_number    <= tick_next;
			run_hash       <= hash_next;
			alpha          <= '0;
			catching_up    <= flag_q;
			catch_up_total <= count_q;
			is_paused      <= pause_q;
			last           <= 1'b0;
		end else if (cmd.emit_final) begin
			step_valid     <= (done_q != '0);
			tick_number    <= tick_q;
			run_hash       <= hash_q;
			alpha          <= alpha_q;
			catching_up    <= flag_q;
			catch_up_total <= count_q;
			is_paused      <= pause_q;
			last           <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ftts_pkg::*;

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

	typedef struct {
		logic                step_valid;
		logic [63:0]         tick_number;
		logic [63:0]         run_hash;
		logic [ALPHA_W-1:0]  alpha;
		logic                catching_up;
		logic [COUNT_W-1:0]  catch_up_total;
		logic                is_paused;
		logic                last;
	} tick_res_t;

	// Tracks the tick state of the block and holds the results still owed by it.
	class tick_scoreboard;
		tick_res_t            ticks_due[$];
		logic [PERIOD_W-1:0]  period;
		logic [LIMIT_W-1:0]   limit;
		logic [ACC_W-1:0]     accum;
		logic [63:0]          ticks;
		logic [63:0]          hash;
		logic [ALPHA_W-1:0]   frac;
		logic                 lagging;
		logic [COUNT_W-1:0]   lag_count;
		logic                 held;
		int unsigned          errors;
		int unsigned          items_in;
		int unsigned          results_seen;
		int unsigned          ticks_run;
		int unsigned          catchups;

		function new();
			period = PERIOD_RST;
			limit = CATCH_RST;
			errors = 0;
			items_in = 0;
			results_seen = 0;
			ticks_run = 0;
			catchups = 0;
			clear();
		endfunction

		function void clear();
			accum = '0;
			ticks = '0;
			hash = HASH_SEED;
			frac = '0;
			lagging = 1'b0;
			lag_count = '0;
			held = 1'b0;
		endfunction

		function tick_res_t snapshot(logic stepped);
			tick_res_t r;
			r.step_valid = stepped;
			r.tick_number = ticks;
			r.run_hash = hash;
			r.alpha = '0;
			r.catching_up = lagging;
			r.catch_up_total = lag_count;
			r.is_paused = held;
			r.last = 1'b0;
			return r;
		endfunction

		function void note_item(op_t o, logic [PERIOD_W-1:0] el);
			logic [PERIOD_W-1:0] per;
			int unsigned lim;
			int unsigned done;
			logic [63:0] scaled;
			tick_res_t res;
			bit have;
			have = 0;
			items_in++;
			if (o == OP_ADVANCE && !held) begin
				per = (period == 0) ? 1 : period;
				lim = (limit < MAX_TICKS_DEF) ? limit : MAX_TICKS_DEF;
				accum = accum + el;
				lagging = 1'b0;
				done = 0;
				// After a catch-up the accumulator is zero, so the loop ends by itself.
				while (accum >= {1'b0, per}) begin
					if (done >= lim) begin
						lagging = 1'b1;
						lag_count = lag_count + 1;
						accum = '0;
						catchups++;
					end else begin
						if (have)
							ticks_due.push_back(res);
						ticks = ticks + 1;
						done++;
						accum = accum - per;
						hash = (hash ^ ticks) * FNV_PRIME;
						res = snapshot(1'b1);
						have = 1;
						ticks_run++;
					end
				end
				if (accum >= {1'b0, per}) begin
					frac = {ALPHA_W{1'b1}};
				end else begin
					scaled = {31'b0, accum} << FRACTION_BITS_DEF;
					frac = scaled / per;
				end
			end else if (o == OP_PAUSE) begin
				held = 1'b1;
			end else if (o == OP_RESUME) begin
				held = 1'b0;
			end else if (o == OP_RESTART) begin
				clear();
			end
			if (!have)
				res = snapshot(1'b0);
			res.alpha = frac;
			res.catching_up = lagging;
			res.catch_up_total = lag_count;
			res.is_paused = held;
			res.last = 1'b1;
			ticks_due.push_back(res);
		endfunction

		function void diff(string nm, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h actual %0h", $time, nm, want, got);
				errors++;
			end
		endfunction

		function void check_tick(tick_res_t got);
			tick_res_t want;
			results_seen++;
			if (ticks_due.size() == 0) begin
				$display("%0t: result transfer with nothing pending, tick_number %0h",
					$time, got.tick_number);
				errors++;
			end else begin
				want = ticks_due.pop_front();
				diff("step_valid", want.step_valid, got.step_valid);
				diff("tick_number", want.tick_number, got.tick_number);
				diff("run_hash", want.run_hash, got.run_hash);
				diff("alpha", want.alpha, got.alpha);
				diff("catching_up", want.catching_up, got.catching_up);
				diff("catch_up_total", want.catch_up_total, got.catch_up_total);
				diff("is_paused", want.is_paused, got.is_paused);
				diff("last", want.last, got.last);
			end
		endfunction

		function int pending();
			return ticks_due.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	op_t                 in_op = OP_ADVANCE;
	logic [PERIOD_W-1:0] in_elapsed = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                step_valid;
	logic [HASH_W-1:0]   tick_number;
	logic [HASH_W-1:0]   run_hash;
	logic [ALPHA_W-1:0]  alpha;
	logic                catching_up;
	logic [COUNT_W-1:0]  catch_up_total;
	logic                is_paused;
	logic                last;

	tick_scoreboard sb;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned reg_errors = 0;
	int unsigned reg_writes = 0;

	int unsigned idle_pct[4] = '{0, 83, 0, 34};
	int unsigned stall_pct[4] = '{0, 0, 83, 34};
	logic [PERIOD_W-1:0] phase_period[7] = '{1000, 1, 0, 32'hFFFF_FFFF, 7, 250, 16667};
	logic [LIMIT_W-1:0] phase_limit[7] = '{8, 64, 0, 127, 3, 64, 8};

	fixed_timestep_tick_scheduler_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (in_op),
		.elapsed        (in_elapsed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_valid     (step_valid),
		.tick_number    (tick_number),
		.run_hash       (run_hash),
		.alpha          (alpha),
		.catching_up    (catching_up),
		.catch_up_total (catch_up_total),
		.is_paused      (is_paused),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Result side: the stall seen here is the one that held during the cycle just ended.
	always @(posedge clk) begin : result_mon
		tick_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.step_valid = step_valid;
			got.tick_number = tick_number;
			got.run_hash = run_hash;
			got.alpha = alpha;
			got.catching_up = catching_up;
			got.catch_up_total = catch_up_total;
			got.is_paused = is_paused;
			got.last = last;
			sb.check_tick(got);
		end
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic send_item(input op_t o, input logic [PERIOD_W-1:0] el);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_op <= o;
		in_elapsed <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(o, el);
	endtask

	// Waits until every owed result has come and the divider has surely gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (FRACTION_BITS_DEF + 8) @(posedge clk);
	endtask

	// Writes a register, then reads it back through the same port.
	task automatic set_reg(input logic idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] mask;
		mask = (idx == REG_TICK_PERIOD) ? {APB_DW{1'b1}} : APB_DW'({LIMIT_W{1'b1}});
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (val & mask)) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, idx, val & mask, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_TICK_PERIOD)
			sb.period = val;
		else
			sb.limit = val[LIMIT_W-1:0];
		reg_writes++;
	endtask

	initial begin : stim
		int unsigned ph;
		int unsigned k;
		int unsigned r;
		op_t o;
		logic [63:0] per;
		logic [63:0] span;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: period 16667, limit 8.
		send_item(OP_ADVANCE, 32'd0);
		send_item(OP_ADVANCE, 32'd16666);
		send_item(OP_ADVANCE, 32'd1);
		send_item(OP_ADVANCE, 32'd50001);
		send_item(OP_ADVANCE, 32'd133336);
		send_item(OP_ADVANCE, 32'd150003);
		send_item(OP_ADVANCE, 32'hFFFF_FFFF);
		send_item(OP_ADVANCE, 32'd0);
		send_item(OP_PAUSE, 32'h5555_5555);
		send_item(OP_ADVANCE, 32'hFFFF_FFFF);
		send_item(OP_PAUSE, 32'd0);
		send_item(OP_RESUME, 32'hAAAA_AAAA);
		send_item(OP_RESUME, 32'd0);
		send_item(OP_ADVANCE, 32'h5555_5555);
		send_item(OP_ADVANCE, 32'hAAAA_AAAA);
		send_item(OP_RESTART, 32'hFFFF_FFFF);
		send_item(OP_ADVANCE, 32'd8000);
		send_item(OP_RESTART, 32'd0);
		send_item(OP_ADVANCE, 32'd16667);
		send_item(OP_PAUSE, 32'd0);
		send_item(OP_RESTART, 32'd0);
		send_item(OP_ADVANCE, 32'd20000);
		settle();

		for (ph = 0; ph < 7; ph++) begin
			set_reg(REG_TICK_PERIOD, phase_period[ph]);
			set_reg(REG_MAX_CATCH_UP, APB_DW'(phase_limit[ph]));
			send_idle = idle_pct[ph % 4];
			recv_stall = stall_pct[ph % 4];
			for (k = 0; k < 19; k++) begin
				r = $urandom_range(99);
				if (r < 75)
					o = OP_ADVANCE;
				else if (r < 83)
					o = OP_PAUSE;
				else if (r < 93)
					o = OP_RESUME;
				else
					o = OP_RESTART;
				per = (sb.period == 0) ? 64'd1 : {32'b0, sb.period};
				case ($urandom_range(9))
				0: span = 64'd0;
				1: span = {32'b0, $urandom};
				2: span = 64'hFFFF_FFFF;
				3, 4, 5: span = per * $urandom_range(sb.limit + 1) + $urandom_range(per - 1);
				default: span = $urandom_range(per);
				endcase
				if (span > 64'hFFFF_FFFF)
					span = 64'hFFFF_FFFF;
				send_item(o, span[PERIOD_W-1:0]);
			end
			settle();
		end

		$display("covered %0d input transfers and %0d result transfers over %0d register writes",
			sb.items_in, sb.results_seen, reg_writes);
		$display("predicted %0d ticks and %0d catch-ups", sb.ticks_run, sb.catchups);
		if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results still owed", sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
